// ===== src/owbe_pkg.sv =====
package owbe_pkg;

    // tick counter width
    localparam int COUNT_BITS = 10;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // timing registers
    localparam int CFG_W = 10;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [CFG_W-1:0] t_ticks;
    typedef logic [CMP_W-1:0] t_cmp;

    localparam t_ticks RST_RESET_LOW     = t_ticks'(480);
    localparam t_ticks RST_PRESENCE_WAIT = t_ticks'(60);
    localparam t_ticks RST_RECOVERY      = t_ticks'(420);
    localparam t_ticks RST_SLOT_LOW      = t_ticks'(1);
    localparam t_ticks RST_WRITE_HOLD    = t_ticks'(60);
    localparam t_ticks RST_READ_SAMPLE   = t_ticks'(14);
    localparam t_ticks RST_READ_REST     = t_ticks'(45);

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_RESET_LOW     = 3'd0,
        CFG_PRESENCE_WAIT = 3'd1,
        CFG_RECOVERY      = 3'd2,
        CFG_SLOT_LOW      = 3'd3,
        CFG_WRITE_HOLD    = 3'd4,
        CFG_READ_SAMPLE   = 3'd5,
        CFG_READ_REST     = 3'd6
    } t_cfg_reg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_REC  = 4'd3,
        PH_SLOT_LOW = 4'd4,
        PH_WR_HOLD  = 4'd5,
        PH_RD_WAIT  = 4'd6,
        PH_RD_REST  = 4'd7
    } t_phase;

    // classified word as it sits in the queue
    typedef struct packed {
        t_op        op;
        logic       level;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

endpackage

// ===== src/owbe_front.sv =====
module owbe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_opcode,
    input  logic              i_line_level,
    input  logic [7:0]        i_write_data,
    output owbe_pkg::t_head   o_head,
    input  logic              i_pop
);

    owbe_pkg::t_item r_mem [owbe_pkg::QUEUE_DEPTH];
    logic [owbe_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [owbe_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [owbe_pkg::QCNT_W-1:0] r_count;
    owbe_pkg::t_item w_item;
    logic w_push;
    logic w_pop;

    // keep only the fields each kind of word uses
    always_comb begin
        w_item.op    = owbe_pkg::t_op'(i_opcode);
        w_item.level = 1'b0;
        w_item.data  = 8'd0;
        unique case (w_item.op)
            owbe_pkg::OP_TICK: begin
                w_item.level = i_line_level;
            end
            owbe_pkg::OP_WRITE: begin
                w_item.data = i_write_data;
            end
            default: begin
            end
        endcase
    end

    assign o_stall = (r_count == owbe_pkg::QCNT_W'(owbe_pkg::QUEUE_DEPTH));
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == owbe_pkg::QPTR_W'(owbe_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == owbe_pkg::QPTR_W'(owbe_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== src/owbe_back.sv =====
module owbe_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [owbe_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [owbe_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  owbe_pkg::t_head                    i_head,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_drive_low,
    output logic                               o_busy_res,
    output logic                               o_done_res,
    output logic                               o_presence_error,
    output logic [7:0]                         o_read_data,
    output logic                               o_command_rejected
);

    owbe_pkg::t_ticks r_reset_low;
    owbe_pkg::t_ticks r_presence_wait;
    owbe_pkg::t_ticks r_recovery;
    owbe_pkg::t_ticks r_slot_low;
    owbe_pkg::t_ticks r_write_hold;
    owbe_pkg::t_ticks r_read_sample;
    owbe_pkg::t_ticks r_read_rest;

    owbe_pkg::t_phase r_phase, n_phase;
    owbe_pkg::t_count r_tick, n_tick;
    logic [2:0]       r_bit, n_bit;
    logic [7:0]       r_shift, n_shift;
    logic             r_pres, n_pres;
    owbe_pkg::t_op    r_opk, n_opk;
    logic [7:0]       r_last, n_last;

    owbe_pkg::t_count w_tick_inc;
    owbe_pkg::t_ticks w_limit;
    logic             w_elapsed;
    logic             w_done;
    logic             w_rej;
    logic             w_drive;
    logic [7:0]       w_shift_end;

    logic r_valid;
    logic r_drive, r_busy, r_done, r_pres_out, r_rej;
    logic [7:0] r_rd_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_low     <= owbe_pkg::RST_RESET_LOW;
            r_presence_wait <= owbe_pkg::RST_PRESENCE_WAIT;
            r_recovery      <= owbe_pkg::RST_RECOVERY;
            r_slot_low      <= owbe_pkg::RST_SLOT_LOW;
            r_write_hold    <= owbe_pkg::RST_WRITE_HOLD;
            r_read_sample   <= owbe_pkg::RST_READ_SAMPLE;
            r_read_rest     <= owbe_pkg::RST_READ_REST;
        end else if (i_cfg_we) begin
            unique case (owbe_pkg::t_cfg_reg'(i_cfg_addr))
                owbe_pkg::CFG_RESET_LOW:     r_reset_low     <= i_cfg_wdata;
                owbe_pkg::CFG_PRESENCE_WAIT: r_presence_wait <= i_cfg_wdata;
                owbe_pkg::CFG_RECOVERY:      r_recovery      <= i_cfg_wdata;
                owbe_pkg::CFG_SLOT_LOW:      r_slot_low      <= i_cfg_wdata;
                owbe_pkg::CFG_WRITE_HOLD:    r_write_hold    <= i_cfg_wdata;
                owbe_pkg::CFG_READ_SAMPLE:   r_read_sample   <= i_cfg_wdata;
                owbe_pkg::CFG_READ_REST:     r_read_rest     <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // take the next word when the output slot is free or being emptied
    assign o_pop = i_head.valid && (!r_valid || !i_stall);

    assign w_tick_inc = (r_tick == owbe_pkg::COUNT_MAX) ? r_tick : r_tick + 1'b1;

    always_comb begin
        unique case (r_phase)
            owbe_pkg::PH_RST_LOW:  w_limit = r_reset_low;
            owbe_pkg::PH_RST_WAIT: w_limit = r_presence_wait;
            owbe_pkg::PH_RST_REC:  w_limit = r_recovery;
            owbe_pkg::PH_SLOT_LOW: w_limit = r_slot_low;
            owbe_pkg::PH_WR_HOLD:  w_limit = r_write_hold;
            owbe_pkg::PH_RD_WAIT:  w_limit = r_read_sample;
            owbe_pkg::PH_RD_REST:  w_limit = r_read_rest;
            default:               w_limit = r_slot_low;
        endcase
    end

    // a zero length ends on the first tick, an unreachable one at saturation
    assign w_elapsed = (owbe_pkg::t_cmp'(w_tick_inc) >= owbe_pkg::t_cmp'(w_limit)) ||
                       (w_tick_inc == owbe_pkg::COUNT_MAX);

    assign w_shift_end = (r_phase == owbe_pkg::PH_WR_HOLD) ? {1'b0, r_shift[7:1]} : r_shift;

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_pres  = r_pres;
        n_opk   = r_opk;
        n_last  = r_last;
        w_done  = 1'b0;
        w_rej   = 1'b0;
        if (i_head.item.op == owbe_pkg::OP_TICK) begin
            if (r_phase != owbe_pkg::PH_IDLE) begin
                n_tick = w_tick_inc;
                unique case (r_phase)
                    owbe_pkg::PH_RST_LOW: begin
                        if (w_elapsed) begin
                            n_phase = owbe_pkg::PH_RST_WAIT;
                            n_tick  = '0;
                        end
                    end
                    owbe_pkg::PH_RST_WAIT: begin
                        if (w_elapsed) begin
                            n_pres  = i_head.item.level;
                            n_phase = owbe_pkg::PH_RST_REC;
                            n_tick  = '0;
                        end
                    end
                    owbe_pkg::PH_RST_REC: begin
                        if (w_elapsed) begin
                            n_phase = owbe_pkg::PH_IDLE;
                            n_tick  = '0;
                            w_done  = 1'b1;
                        end
                    end
                    owbe_pkg::PH_SLOT_LOW: begin
                        if (w_elapsed) begin
                            n_phase = (r_opk == owbe_pkg::OP_WRITE) ?
                                      owbe_pkg::PH_WR_HOLD : owbe_pkg::PH_RD_WAIT;
                            n_tick  = '0;
                        end
                    end
                    owbe_pkg::PH_RD_WAIT: begin
                        if (w_elapsed) begin
                            n_shift = {i_head.item.level, r_shift[7:1]};
                            n_phase = owbe_pkg::PH_RD_REST;
                            n_tick  = '0;
                        end
                    end
                    owbe_pkg::PH_WR_HOLD, owbe_pkg::PH_RD_REST: begin
                        if (w_elapsed) begin
                            n_shift = w_shift_end;
                            n_tick  = '0;
                            if (r_bit == 3'd7) begin
                                if (r_opk == owbe_pkg::OP_READ) begin
                                    n_last = w_shift_end;
                                end
                                n_phase = owbe_pkg::PH_IDLE;
                                w_done  = 1'b1;
                            end else begin
                                n_bit   = r_bit + 1'b1;
                                n_phase = owbe_pkg::PH_SLOT_LOW;
                            end
                        end
                    end
                    default: begin
                        n_phase = owbe_pkg::PH_IDLE;
                        n_tick  = '0;
                    end
                endcase
            end
        end else if (r_phase != owbe_pkg::PH_IDLE) begin
            w_rej = 1'b1;
        end else begin
            n_opk = i_head.item.op;
            n_bit = '0;
            n_tick = '0;
            if (i_head.item.op == owbe_pkg::OP_RESET) begin
                n_phase = owbe_pkg::PH_RST_LOW;
            end else begin
                n_shift = i_head.item.data;
                n_phase = owbe_pkg::PH_SLOT_LOW;
            end
        end

        unique case (n_phase)
            owbe_pkg::PH_RST_LOW, owbe_pkg::PH_SLOT_LOW: w_drive = 1'b1;
            owbe_pkg::PH_WR_HOLD:                        w_drive = ~n_shift[0];
            default:                                     w_drive = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= owbe_pkg::PH_IDLE;
            r_tick  <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_pres  <= 1'b1;
            r_opk   <= owbe_pkg::OP_TICK;
            r_last  <= '0;
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_pres  <= n_pres;
            r_opk   <= n_opk;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_drive    <= w_drive;
            r_busy     <= (n_phase != owbe_pkg::PH_IDLE);
            r_done     <= w_done;
            r_pres_out <= n_pres;
            r_rd_out   <= n_last;
            r_rej      <= w_rej;
        end
    end

    assign o_valid            = r_valid;
    assign o_drive_low        = r_drive;
    assign o_busy_res         = r_busy;
    assign o_done_res         = r_done;
    assign o_presence_error   = r_pres_out;
    assign o_read_data        = r_rd_out;
    assign o_command_rejected = r_rej;

endmodule

// ===== src/onewire_master_byte_engine_core.sv =====
// one-wire bus master, byte engine
// input channel (i_valid / o_stall): each word is either a microsecond tick
// carrying the sampled bus level (opcode 0) or a command: start reset (1),
// write byte (2) or read byte (3). write data is used by write commands only.
// output channel (o_valid / i_stall): one word per input word, with the line
// drive, busy, done, presence level, last read byte and a rejected flag for a
// command that arrived while an operation was running.
// throughput is one word per clock while the output is not stalled; the line
// state machine updates once per word. a result is registered: the input
// word is written into the queue, the queue head is read combinationally
// and the engine writes the output register when it pops the word.
// when the receiver stalls the output register holds its word, the engine
// stops and the input queue fills; o_stall rises once both entries are taken.
// timing registers are written through i_cfg_we / i_cfg_addr / i_cfg_wdata by
// the user only while the block is idle, not enforced; unused indexes are ignored.
// reset (i_rst_n low, synchronous) empties the queue and output, puts the
// engine in idle, clears the read byte, sets presence to one and loads the
// default timing values.
module onewire_master_byte_engine_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_opcode,
    input  logic                               i_line_level,
    input  logic [7:0]                         i_write_data,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_drive_low,
    output logic                               o_busy_res,
    output logic                               o_done_res,
    output logic                               o_presence_error,
    output logic [7:0]                         o_read_data,
    output logic                               o_command_rejected,
    input  logic                               i_cfg_we,
    input  logic [owbe_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [owbe_pkg::CFG_W-1:0]         i_cfg_wdata
);

    owbe_pkg::t_head w_head;
    logic            w_pop;

    owbe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_line_level (i_line_level),
        .i_write_data (i_write_data),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    owbe_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_head             (w_head),
        .o_pop              (w_pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_drive_low        (o_drive_low),
        .o_busy_res         (o_busy_res),
        .o_done_res         (o_done_res),
        .o_presence_error   (o_presence_error),
        .o_read_data        (o_read_data),
        .o_command_rejected (o_command_rejected)
    );

    // an operation that just finished leaves nothing running
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> !o_busy_res)
        else $error("done word still reports busy");

    // the line is only pulled low while an operation runs
    a_drive_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_drive_low) |-> o_busy_res)
        else $error("line driven low while idle");

    // a rejected command cannot also complete an operation
    a_reject_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_command_rejected) |-> (!o_done_res && o_busy_res))
        else $error("rejected command with done or idle engine");

    // the engine never pops while the output word is stalled
    a_no_pop_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !w_pop)
        else $error("queue popped while output stalled");

endmodule
